[rtl/rils_pkg.sv]
`timescale 1ns / 1ps

package rils_pkg;

   localparam int VALUE_BITS_DEFAULT = 64;
   localparam int VALUE_WIDTH = 64;
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [1:0] {
      RX_DEC = 2'd0,
      RX_HEX = 2'd1,
      RX_OCT = 2'd2,
      RX_BIN = 2'd3
   } radix_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_WARNING  = 2'd1,
      ST_OVERFLOW = 2'd2,
      ST_FRACTION = 2'd3
   } status_type;

   localparam logic [7:0] LIMIT_HEX  = 8'd16;
   localparam logic [7:0] LIMIT_OCT  = 8'd22;
   localparam logic [7:0] LIMIT_BIN  = 8'd64;
   localparam logic [7:0] LIMIT_DEC  = 8'd19;
   localparam logic [7:0] LIMIT_ZERO = 8'd20;

   typedef struct packed {
      logic       first;
      logic [3:0] digit;
      logic       dec_ok;
      logic       hex_ok;
      logic       oct_ok;
      logic       bin_ok;
      logic       dot;
      logic       prefix_hit;
      radix_type  prefix_radix;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

   typedef struct packed {
      logic      empty;
      logic      full;
      entry_type head;
   } queue_status_type;

   function automatic logic [7:0] sat_inc(input logic [7:0] v);
      sat_inc = (v == 8'hff) ? v : v + 8'd1;
   endfunction

endpackage

[rtl/rils_if.sv]
`timescale 1ns / 1ps

interface rils_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] character;
   logic       first;

   modport source (output valid, character, first, input ready);
   modport sink (input valid, character, first, output ready);
endinterface

interface rils_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] value;
   logic [1:0]  radix;
   logic [7:0]  length;
   logic [1:0]  status;

   modport source (output valid, value, radix, length, status, input ready);
   modport sink (input valid, value, radix, length, status, output ready);
endinterface

[rtl/rils_front.sv]
`timescale 1ns / 1ps

module rils_front (
   rils_req_if.sink            req_channel,
   input  logic                queue_full,
   output rils_pkg::push_type  push
);

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_ONE   = 8'h31;
   localparam logic [7:0] CH_SEVEN = 8'h37;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LF    = 8'h66;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UF    = 8'h46;
   localparam logic [7:0] CH_DOT   = 8'h2e;
   localparam logic [7:0] CH_LX    = 8'h78;
   localparam logic [7:0] CH_UX    = 8'h58;
   localparam logic [7:0] CH_LO    = 8'h6f;
   localparam logic [7:0] CH_UO    = 8'h4f;
   localparam logic [7:0] CH_LB    = 8'h62;
   localparam logic [7:0] CH_UB    = 8'h42;

   logic [7:0] c;
   logic       lower_hex;
   logic       upper_hex;
   logic [7:0] dec_val;
   logic [7:0] lower_val;
   logic [7:0] upper_val;

   assign c = req_channel.character;
   assign req_channel.ready = !queue_full;

   assign dec_val   = c - CH_ZERO;
   assign lower_val = c - CH_LA + 8'd10;
   assign upper_val = c - CH_UA + 8'd10;

   always_comb begin
      lower_hex = c inside {[CH_LA:CH_LF]};
      upper_hex = c inside {[CH_UA:CH_UF]};
      push.valid              = req_channel.valid && !queue_full;
      push.entry.first        = req_channel.first;
      push.entry.dec_ok       = c inside {[CH_ZERO:CH_NINE]};
      push.entry.oct_ok       = c inside {[CH_ZERO:CH_SEVEN]};
      push.entry.bin_ok       = c inside {[CH_ZERO:CH_ONE]};
      push.entry.hex_ok       = push.entry.dec_ok || lower_hex || upper_hex;
      push.entry.dot          = (c == CH_DOT);
      if (push.entry.dec_ok) begin
         push.entry.digit = dec_val[3:0];
      end else if (lower_hex) begin
         push.entry.digit = lower_val[3:0];
      end else if (upper_hex) begin
         push.entry.digit = upper_val[3:0];
      end else begin
         push.entry.digit = 4'd0;
      end
      push.entry.prefix_hit   = 1'b1;
      push.entry.prefix_radix = rils_pkg::RX_DEC;
      if (c == CH_LX || c == CH_UX) begin
         push.entry.prefix_radix = rils_pkg::RX_HEX;
      end else if (c == CH_LO || c == CH_UO) begin
         push.entry.prefix_radix = rils_pkg::RX_OCT;
      end else if (c == CH_LB || c == CH_UB) begin
         push.entry.prefix_radix = rils_pkg::RX_BIN;
      end else begin
         push.entry.prefix_hit = 1'b0;
      end
   end

endmodule

[rtl/rils_queue.sv]
`timescale 1ns / 1ps

module rils_queue #(
   parameter int DEPTH = rils_pkg::QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  rils_pkg::push_type         push,
   input  logic                       pop,
   output rils_pkg::queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   rils_pkg::entry_type slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             do_push;

   assign do_push      = push.valid && (count_ff != CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.head  = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push.entry;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("pop from empty queue");
   a_fill: assert property (@(posedge clock) disable iff (reset)
      (do_push && !pop) |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("queue count did not advance on push");
`endif

endmodule

[rtl/rils_back.sv]
`timescale 1ns / 1ps

module rils_back #(
   parameter int VALUE_BITS = rils_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  rils_pkg::queue_status_type queue,
   output logic                       pop,
   rils_rsp_if.source                 rsp_channel
);

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_PREFIX = 2'd1,
      PH_DIGITS = 2'd2
   } phase_type;

   phase_type            phase_ff, phase_in;
   rils_pkg::radix_type  rx_ff, rx_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic [VALUE_BITS-1:0] prev_ff, prev_in;
   logic [7:0]           sc_ff, sc_in;
   logic [7:0]           sl_ff, sl_in;
   logic                 nz_ff, nz_in;
   logic [7:0]           cc_ff, cc_in;
   logic                 ovf_ff, ovf_in;

   logic                 out_valid_ff, out_valid_in;
   logic [63:0]          out_value_ff;
   logic [1:0]           out_radix_ff;
   logic [7:0]           out_length_ff;
   logic [1:0]           out_status_ff;

   rils_pkg::entry_type  e;
   rils_pkg::status_type st;
   logic                 emit;
   logic                 is_zero;
   logic                 digit_ok;
   logic [7:0]           step_sl;
   logic                 step_nz;
   logic [7:0]           step_sc;
   logic                 shift_ok;
   logic [VALUE_BITS-1:0] scaled;
   logic [VALUE_BITS-1:0] acc_m;
   logic [VALUE_BITS:0]  sum;
   logic                 add_ok;
   logic [7:0]           prefix_limit;

   assign e       = queue.head;
   assign pop     = !queue.empty && (!out_valid_ff || rsp_channel.ready);
   assign is_zero = e.dec_ok && (e.digit == 4'd0);

   always_comb begin
      case (rx_ff)
         rils_pkg::RX_HEX: begin
            scaled   = acc_ff << 4;
            digit_ok = e.hex_ok;
         end
         rils_pkg::RX_OCT: begin
            scaled   = acc_ff << 3;
            digit_ok = e.oct_ok;
         end
         rils_pkg::RX_BIN: begin
            scaled   = acc_ff << 1;
            digit_ok = e.bin_ok;
         end
         default: begin
            scaled   = (acc_ff << 3) + (acc_ff << 1);
            digit_ok = e.dec_ok;
         end
      endcase
      case (e.prefix_radix)
         rils_pkg::RX_HEX: prefix_limit = rils_pkg::LIMIT_HEX;
         rils_pkg::RX_OCT: prefix_limit = rils_pkg::LIMIT_OCT;
         rils_pkg::RX_BIN: prefix_limit = rils_pkg::LIMIT_BIN;
         default:          prefix_limit = rils_pkg::LIMIT_DEC;
      endcase
      if (!nz_ff && is_zero) begin
         step_sl = rils_pkg::sat_inc(sl_ff);
         step_nz = nz_ff;
      end else begin
         step_sl = sl_ff;
         step_nz = 1'b1;
      end
      step_sc  = rils_pkg::sat_inc(sc_ff);
      shift_ok = (step_sc <= step_sl);
      acc_m    = shift_ok ? scaled : acc_ff;
      sum      = {1'b0, acc_m} + {{(VALUE_BITS - 3){1'b0}}, e.digit};
      add_ok   = !sum[VALUE_BITS] && (acc_m >= prev_ff);
   end

   always_comb begin
      phase_in     = phase_ff;
      rx_in        = rx_ff;
      acc_in       = acc_ff;
      prev_in      = prev_ff;
      sc_in        = sc_ff;
      sl_in        = sl_ff;
      nz_in        = nz_ff;
      cc_in        = cc_ff;
      ovf_in       = ovf_ff;
      emit         = 1'b0;
      st           = rils_pkg::ST_OK;
      if (pop) begin
         if (e.first) begin
            if (!e.dec_ok) begin
               phase_in = PH_IDLE;
            end else begin
               rx_in    = rils_pkg::RX_DEC;
               acc_in   = VALUE_BITS'(e.digit);
               prev_in  = VALUE_BITS'(e.digit);
               sc_in    = 8'd0;
               sl_in    = is_zero ? rils_pkg::LIMIT_ZERO : rils_pkg::LIMIT_DEC;
               ovf_in   = 1'b0;
               cc_in    = 8'd1;
               nz_in    = !is_zero;
               phase_in = is_zero ? PH_PREFIX : PH_DIGITS;
            end
         end else begin
            case (phase_ff)
               PH_IDLE: begin
               end
               PH_PREFIX, PH_DIGITS: begin
                  if (phase_ff == PH_PREFIX && e.prefix_hit) begin
                     rx_in    = e.prefix_radix;
                     acc_in   = '0;
                     prev_in  = '0;
                     sc_in    = 8'd0;
                     sl_in    = prefix_limit;
                     nz_in    = 1'b0;
                     cc_in    = 8'd2;
                     phase_in = PH_DIGITS;
                  end else if (rx_ff == rils_pkg::RX_DEC && e.dot) begin
                     emit = 1'b1;
                     st   = ovf_ff ? rils_pkg::ST_OVERFLOW : rils_pkg::ST_FRACTION;
                  end else if (!digit_ok) begin
                     emit = 1'b1;
                     if (ovf_ff) begin
                        st = rils_pkg::ST_OVERFLOW;
                     end else if ((rx_ff == rils_pkg::RX_DEC || rx_ff == rils_pkg::RX_OCT)
                                  && sc_ff == sl_ff) begin
                        st = rils_pkg::ST_WARNING;
                     end
                  end else begin
                     phase_in = PH_DIGITS;
                     sl_in    = step_sl;
                     nz_in    = step_nz;
                     sc_in    = step_sc;
                     cc_in    = rils_pkg::sat_inc(cc_ff);
                     if (add_ok) begin
                        acc_in  = sum[VALUE_BITS-1:0];
                        prev_in = sum[VALUE_BITS-1:0];
                     end else begin
                        acc_in  = acc_m;
                     end
                     ovf_in = ovf_ff || !shift_ok || !add_ok;
                  end
                  if (emit) begin
                     phase_in = PH_IDLE;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
      if (pop) begin
         out_valid_in = emit;
      end else if (rsp_channel.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
      rx_ff   <= rx_in;
      acc_ff  <= acc_in;
      prev_ff <= prev_in;
      sc_ff   <= sc_in;
      sl_ff   <= sl_in;
      nz_ff   <= nz_in;
      cc_ff   <= cc_in;
      ovf_ff  <= ovf_in;
      if (pop && emit) begin
         out_value_ff  <= rils_pkg::VALUE_WIDTH'(acc_ff);
         out_radix_ff  <= rx_ff;
         out_length_ff <= cc_ff;
         out_status_ff <= st;
      end
   end

   assign rsp_channel.valid  = out_valid_ff;
   assign rsp_channel.value  = out_value_ff;
   assign rsp_channel.radix  = out_radix_ff;
   assign rsp_channel.length = out_length_ff;
   assign rsp_channel.status = out_status_ff;

`ifndef NO_ASSERTIONS
   a_emit_idle: assert property (@(posedge clock) disable iff (reset)
      (pop && emit) |=> phase_ff == PH_IDLE)
      else $error("literal end did not return to idle");
   a_bad_start: assert property (@(posedge clock) disable iff (reset)
      (pop && e.first && !e.dec_ok) |=> phase_ff == PH_IDLE)
      else $error("non-digit start left scanner busy");
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(pop && emit))
      else $error("result raised without a literal end");
`endif

endmodule

[rtl/radix_integer_literal_scanner_unit.sv]
`timescale 1ns / 1ps

// Integer literal scanner with radix prefix.
// req_channel carries one source byte per beat with a first flag on the
// opening decimal digit; rsp_channel returns one beat per literal: value,
// radix, length and status. A literal ends on the first byte that is not a
// digit of its radix; that byte gives the result and is not counted.
// Throughput: one byte per cycle while no result waits on the receiver;
// the multiply-by-base and 64-bit add in the back-end digit step are
// combinational. The ending byte is written into the queue, decoded at
// the queue head and loaded into the result register.
// Reset empties the queue, clears the result valid flag and sets the scan
// phase to idle; no result is pending afterwards.
// When the receiver stalls, the back end holds the pending result and stops
// draining; the queue absorbs up to four bytes, then req_channel.ready drops.

module radix_integer_literal_scanner_unit #(
   parameter int VALUE_BITS = rils_pkg::VALUE_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   rils_req_if.sink    req_channel,
   rils_rsp_if.source  rsp_channel
);

   rils_pkg::push_type         push;
   rils_pkg::queue_status_type queue_status;
   logic                       pop;

   rils_front u_front (
      .req_channel (req_channel),
      .queue_full  (queue_status.full),
      .push        (push)
   );

   rils_queue #(
      .DEPTH (rils_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .status (queue_status)
   );

   rils_back #(
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue       (queue_status),
      .pop         (pop),
      .rsp_channel (rsp_channel)
   );

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;

   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_BEATS = 1275;
   localparam logic [63:0] VALUE_MAX = '1;

   typedef enum logic [1:0] {
      SCAN_IDLE   = 2'd0,
      SCAN_PREFIX = 2'd1,
      SCAN_DIGITS = 2'd2
   } scan_phase_type;

   typedef enum int {
      END_BYTE,
      END_POINT,
      END_ABANDON
   } literal_end_type;

   typedef struct {
      logic [7:0] character;
      logic       first;
      logic       hold;
   } source_byte_type;

   typedef struct {
      logic [63:0]          value;
      rils_pkg::radix_type  radix;
      logic [7:0]           length;
      rils_pkg::status_type status;
   } literal_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rils_req_if req_bus ();
   rils_rsp_if rsp_bus ();

   radix_integer_literal_scanner_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_channel (req_bus),
      .rsp_channel (rsp_bus)
   );

   always #10 clock = ~clock;

   source_byte_type    pending_bytes[$];
   literal_result_type expected_literals[$];
   int                 bytes_queued = 0;
   int                 owed_count = 0;
   int                 beats_accepted = 0;
   int                 failures = 0;
   int                 cycle_count = 0;

   wire calm = (beats_accepted >= 400) && (beats_accepted < 800);

   // scanner state
   scan_phase_type      sc_phase = SCAN_IDLE;
   rils_pkg::radix_type sc_radix = rils_pkg::RX_DEC;
   logic [63:0]         sc_acc = '0;
   logic [63:0]         sc_prev = '0;
   logic [7:0]          sc_shifts = '0;
   logic [7:0]          sc_limit = '0;
   logic                sc_nonzero = 1'b0;
   logic [7:0]          sc_count = '0;
   logic                sc_overflow = 1'b0;

   function automatic int digit_value(logic [7:0] c, rils_pkg::radix_type rx);
      int v;
      if (c >= "0" && c <= "9") v = c - "0";
      else if (c >= "a" && c <= "f") v = c - "a" + 10;
      else if (c >= "A" && c <= "F") v = c - "A" + 10;
      else v = -1;
      case (rx)
         rils_pkg::RX_HEX: return v;
         rils_pkg::RX_OCT: return (v <= 7) ? v : -1;
         rils_pkg::RX_BIN: return (v <= 1) ? v : -1;
         default: return (v <= 9) ? v : -1;
      endcase
   endfunction

   task automatic scan_byte(input logic [7:0] c, input logic f, output logic produced,
                            output literal_result_type lit);
      int          d;
      logic [63:0] base;
      logic        taken;
      produced = 1'b0;
      taken = 1'b0;
      lit.value = '0;
      lit.radix = rils_pkg::RX_DEC;
      lit.length = '0;
      lit.status = rils_pkg::ST_OK;
      if (f) begin
         if (c < "0" || c > "9") begin
            sc_phase = SCAN_IDLE;
         end else begin
            sc_radix = rils_pkg::RX_DEC;
            sc_acc = 64'(c - "0");
            sc_prev = sc_acc;
            sc_shifts = '0;
            sc_limit = rils_pkg::LIMIT_DEC;
            sc_overflow = 1'b0;
            sc_count = 8'd1;
            if (c == "0") begin
               sc_limit = rils_pkg::LIMIT_ZERO;
               sc_nonzero = 1'b0;
               sc_phase = SCAN_PREFIX;
            end else begin
               sc_nonzero = 1'b1;
               sc_phase = SCAN_DIGITS;
            end
         end
      end else if (sc_phase != SCAN_IDLE) begin
         if (sc_phase == SCAN_PREFIX) begin
            sc_phase = SCAN_DIGITS;
            taken = 1'b1;
            case (c)
               "x", "X": begin
                  sc_radix = rils_pkg::RX_HEX;
                  sc_limit = rils_pkg::LIMIT_HEX;
               end
               "o", "O": begin
                  sc_radix = rils_pkg::RX_OCT;
                  sc_limit = rils_pkg::LIMIT_OCT;
               end
               "b", "B": begin
                  sc_radix = rils_pkg::RX_BIN;
                  sc_limit = rils_pkg::LIMIT_BIN;
               end
               default: taken = 1'b0;
            endcase
            if (taken) begin
               sc_acc = '0;
               sc_prev = '0;
               sc_shifts = '0;
               sc_nonzero = 1'b0;
               sc_count = 8'd2;
            end
         end
         if (!taken) begin
            d = digit_value(c, sc_radix);
            if ((sc_radix == rils_pkg::RX_DEC && c == ".") || d < 0) begin
               produced = 1'b1;
               lit.value = sc_acc;
               lit.radix = sc_radix;
               lit.length = sc_count;
               if (sc_overflow) lit.status = rils_pkg::ST_OVERFLOW;
               else if (sc_radix == rils_pkg::RX_DEC && c == ".")
                  lit.status = rils_pkg::ST_FRACTION;
               else if ((sc_radix == rils_pkg::RX_DEC || sc_radix == rils_pkg::RX_OCT)
                        && sc_shifts == sc_limit)
                  lit.status = rils_pkg::ST_WARNING;
               sc_phase = SCAN_IDLE;
            end else begin
               case (sc_radix)
                  rils_pkg::RX_HEX: base = 64'd16;
                  rils_pkg::RX_OCT: base = 64'd8;
                  rils_pkg::RX_BIN: base = 64'd2;
                  default: base = 64'd10;
               endcase
               if (!sc_nonzero && c == "0") begin
                  if (sc_limit != 8'hff) sc_limit = sc_limit + 8'd1;
               end else begin
                  sc_nonzero = 1'b1;
               end
               if (sc_shifts != 8'hff) sc_shifts = sc_shifts + 8'd1;
               if (sc_shifts <= sc_limit) sc_acc = sc_acc * base;
               else sc_overflow = 1'b1;
               if (sc_acc <= VALUE_MAX - 64'(d) && sc_acc >= sc_prev) begin
                  sc_acc = sc_acc + 64'(d);
                  sc_prev = sc_acc;
               end else begin
                  sc_overflow = 1'b1;
               end
               if (sc_count != 8'hff) sc_count = sc_count + 8'd1;
            end
         end
      end
   endtask

   task automatic note_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      failures++;
   endtask

   task automatic queue_beat(input logic [7:0] c, input logic f);
      pending_bytes.push_back('{character: c, first: f, hold: 1'b0});
      bytes_queued++;
   endtask

   task automatic queue_hold();
      pending_bytes.push_back('{character: 8'd0, first: 1'b0, hold: 1'b1});
   endtask

   function automatic logic [7:0] random_digit(rils_pkg::radix_type rx, bit top,
                                               bit nonzero);
      int hi;
      int v;
      case (rx)
         rils_pkg::RX_HEX: hi = 15;
         rils_pkg::RX_OCT: hi = 7;
         rils_pkg::RX_BIN: hi = 1;
         default: hi = 9;
      endcase
      v = top ? hi : $urandom_range(hi, nonzero ? 1 : 0);
      if (v < 10) return 8'("0" + v);
      return 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
   endfunction

   function automatic logic [7:0] ending_byte(rils_pkg::radix_type rx, bit lone_zero);
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while (digit_value(c, rx) >= 0 ||
             (lone_zero && c inside {"x", "X", "o", "O", "b", "B"}));
      return c;
   endfunction

   task automatic queue_literal(input rils_pkg::radix_type rx, input int zeros,
                                input int digits, input bit top,
                                input literal_end_type ending);
      bit         lone;
      logic [7:0] letter;
      lone = 1'b0;
      if (rx == rils_pkg::RX_DEC) begin
         if (zeros == 0 && digits == 0) digits = 1;
         if (zeros > 0) begin
            queue_beat("0", 1'b1);
            repeat (zeros - 1) queue_beat("0", 1'b0);
         end else begin
            queue_beat(random_digit(rx, top, 1'b1), 1'b1);
            digits--;
         end
         lone = (zeros == 1 && digits == 0);
      end else begin
         case (rx)
            rils_pkg::RX_HEX: letter = $urandom_range(0, 1) ? "x" : "X";
            rils_pkg::RX_OCT: letter = $urandom_range(0, 1) ? "o" : "O";
            default: letter = $urandom_range(0, 1) ? "b" : "B";
         endcase
         queue_beat("0", 1'b1);
         queue_beat(letter, 1'b0);
         repeat (zeros) queue_beat("0", 1'b0);
      end
      for (int i = 0; i < digits; i++) queue_beat(random_digit(rx, top, i == 0), 1'b0);
      case (ending)
         END_BYTE: queue_beat(ending_byte(rx, lone), 1'b0);
         END_POINT: queue_beat(".", 1'b0);
         default: ;
      endcase
   endtask

   always @(posedge clock) begin : driver
      source_byte_type beat;
      logic            load;
      load = 1'b0;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (pending_bytes.size() != 0 && pending_bytes[0].hold) begin
            if (!req_bus.valid && owed_count == 0) void'(pending_bytes.pop_front());
         end else if (pending_bytes.size() != 0 && (calm || $urandom_range(0, 99) >= 20)) begin
            beat = pending_bytes.pop_front();
            load = 1'b1;
         end
         req_bus.valid <= load;
         if (load) begin
            req_bus.character <= beat.character;
            req_bus.first <= beat.first;
         end
      end
   end

   always @(posedge clock)
      rsp_bus.ready <= !reset && (calm || $urandom_range(0, 99) >= 20);

   always @(posedge clock) begin : monitor
      literal_result_type want;
      literal_result_type lit;
      logic               produced;
      int                 delta;
      delta = 0;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_literals.size() == 0) begin
               note_mismatch($sformatf("unexpected result value %h", rsp_bus.value));
            end else begin
               want = expected_literals.pop_front();
               delta--;
               if (rsp_bus.value !== want.value)
                  note_mismatch($sformatf("value %h, want %h", rsp_bus.value, want.value));
               if (rsp_bus.radix !== want.radix)
                  note_mismatch($sformatf("radix %0d, want %0d", rsp_bus.radix, want.radix));
               if (rsp_bus.length !== want.length)
                  note_mismatch($sformatf("length %0d, want %0d", rsp_bus.length,
                                          want.length));
               if (rsp_bus.status !== want.status)
                  note_mismatch($sformatf("status %0d, want %0d", rsp_bus.status,
                                          want.status));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            scan_byte(req_bus.character, req_bus.first, produced, lit);
            if (produced) begin
               expected_literals.push_back(lit);
               delta++;
            end
            beats_accepted <= beats_accepted + 1;
         end
         owed_count <= owed_count + delta;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin : stimulus
      rils_pkg::radix_type rx;
      literal_end_type     ending;
      int                  zeros;
      int                  digits;
      int                  shape;
      int                  pick;
      int                  hold_mark;
      bit                  top;
      req_bus.valid = 1'b0;
      req_bus.character = 8'd0;
      req_bus.first = 1'b0;
      rsp_bus.ready = 1'b0;

      // plain decimal, empty prefix, lone zero, zero then decimal
      queue_beat("7", 1'b1); queue_beat(";", 1'b0);
      queue_beat("0", 1'b1); queue_beat("x", 1'b0); queue_beat(".", 1'b0);
      queue_beat("0", 1'b1); queue_beat(".", 1'b0);
      queue_beat("0", 1'b1); queue_beat("5", 1'b0); queue_beat("A", 1'b0);
      // start on non-digit, then a byte that is ignored while idle
      queue_beat("Z", 1'b1); queue_beat("4", 1'b0);
      // restart abandons the literal in progress
      queue_beat("9", 1'b1); queue_beat("8", 1'b0); queue_beat("1", 1'b1);
      queue_beat(",", 1'b0);
      queue_beat("0", 1'b1); queue_beat("B", 1'b0); queue_beat("1", 1'b0);
      queue_beat("0", 1'b0); queue_beat("2", 1'b0);
      queue_beat("0", 1'b1); queue_beat("O", 1'b0); queue_beat("7", 1'b0);
      queue_beat("8", 1'b0);
      queue_hold();

      hold_mark = bytes_queued + 300;
      while (bytes_queued < RANDOM_BEATS) begin
         pick = $urandom_range(0, 99);
         if (pick < 80) begin
            rx = rils_pkg::radix_type'($urandom_range(0, 3));
            zeros = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 4);
            shape = $urandom_range(0, 99);
            top = 1'b0;
            if (shape < 3) begin
               digits = $urandom_range(250, 300);
            end else if (shape < 20) begin
               case (rx)
                  rils_pkg::RX_HEX: digits = 16;
                  rils_pkg::RX_OCT: digits = 22;
                  rils_pkg::RX_BIN: digits = 64;
                  default: digits = 20;
               endcase
               digits = digits + int'($urandom_range(0, 5)) - 2;
               top = ($urandom_range(0, 3) == 0);
            end else begin
               digits = $urandom_range(0, 12);
            end
            pick = $urandom_range(0, 99);
            if (pick < 13) ending = END_ABANDON;
            else if (pick < 28 && rx == rils_pkg::RX_DEC) ending = END_POINT;
            else ending = END_BYTE;
            queue_literal(rx, zeros, digits, top, ending);
         end else begin
            repeat ($urandom_range(1, 5))
               queue_beat(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
         end
         if (bytes_queued >= hold_mark) begin
            queue_hold();
            hold_mark = hold_mark + 300;
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (pending_bytes.size() != 0 || req_bus.valid || owed_count != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);

      if (expected_literals.size() != 0)
         note_mismatch($sformatf("%0d results never arrived", expected_literals.size()));
      if (failures == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

[sim.f]
rtl/rils_pkg.sv
rtl/rils_if.sv
rtl/rils_front.sv
rtl/rils_queue.sv
rtl/rils_back.sv
rtl/radix_integer_literal_scanner_unit.sv
tb/testbench.sv
